>>> design/skt_pkg.sv
// shared types, constants and helpers of the sorted keyed table
`default_nettype none
package skt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int TALLY_W     = 5;
	localparam int KEY_W       = 16;
	localparam int SPEED_W     = 16;
	localparam int PAYLOAD_W   = 32;
	localparam logic [SPEED_W-1:0] THRESHOLD_RESET = SPEED_W'(5);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_PURGE  = 2'd2,
		OP_DUMP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]     key;
		logic [SPEED_W-1:0]   speed;
		logic [PAYLOAD_W-1:0] payload;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// compare unit outcome
	typedef struct packed {
		logic key_gt;
		logic key_eq;
		logic spd_ge;
	} cmp_t;

	// one result item from the sequencer
	typedef struct packed {
		status_t             status;
		entry_t              ent;
		logic [TALLY_W-1:0]  tally;
		logic                last;
	} res_t;

	function automatic logic [TALLY_W-1:0] to_tally(input logic [CNT_W-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return w[TALLY_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> design/skt_ram.sv
// generic single write port ram with registered read
`default_nettype none
module skt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> design/skt_cmp.sv
// shared compare unit: stored entry against search key and speed threshold
`default_nettype none
module skt_cmp (
	input  wire skt_pkg::entry_t               ent,
	input  wire logic [skt_pkg::KEY_W-1:0]     key,
	input  wire logic [skt_pkg::SPEED_W-1:0]   thr,
	output      skt_pkg::cmp_t                 cmp
);
	import skt_pkg::*;

	always_comb begin
		cmp.key_gt = ent.key > key;
		cmp.key_eq = ent.key == key;
		cmp.spd_ge = ent.speed >= thr;
	end

endmodule
`default_nettype wire

>>> design/skt_seq.sv
// sequencer that walks the entry ram for insert, lookup, purge and dump
`default_nettype none
module skt_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire skt_pkg::op_t                  in_op,
	input  wire skt_pkg::entry_t               in_ent,
	input  wire logic [skt_pkg::SPEED_W-1:0]   thr,
	output      logic                          res_valid,
	input  wire logic                          res_ready,
	output      skt_pkg::res_t                 res
);
	import skt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_INS_WR,
		S_LOOK,
		S_PURGE,
		S_DUMP_RD,
		S_DUMP_OUT,
		S_RESP
	} state_t;

	state_t            state_q;
	entry_t            new_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  kept_q;
	logic [IDX_W-1:0]  rd_ptr_q;
	logic              rd_on_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [IDX_W-1:0]  pos_q;
	res_t              res_q;

	entry_t            rdata;
	cmp_t              cmp;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata;
	logic [IDX_W-1:0]  last_idx;
	logic [CNT_W-1:0]  kept_nx;
	logic              rd_at_end;
	res_t              dump_res;

	skt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

	skt_cmp u_cmp (
		.ent(rdata),
		.key(new_q.key),
		.thr(thr),
		.cmp(cmp)
	);

	assign last_idx  = IDX_W'(cnt_q - CNT_W'(1));
	assign kept_nx   = kept_q + CNT_W'(cmp.spd_ge);
	assign in_ready  = state_q == S_IDLE;
	assign res_valid = (state_q == S_RESP) || (state_q == S_DUMP_OUT);

	// ascending walks stop at the top entry, the insert walk stops at entry zero
	assign rd_at_end = (state_q == S_INS) ? (rd_ptr_q == '0) : (rd_ptr_q == last_idx);

	always_comb begin
		dump_res.status = ST_OK;
		dump_res.ent    = rdata;
		dump_res.tally  = to_tally(cnt_q);
		dump_res.last   = rd_ptr_q == last_idx;
		res = (state_q == S_DUMP_OUT) ? dump_res : res_q;
	end

	// ram write side
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = new_q;
		unique case (state_q)
			S_INS: begin
				// move a larger key up by one slot
				if (pend_s1 && cmp.key_gt) begin
					ram_we    = 1'b1;
					ram_waddr = idx_s1 + IDX_W'(1);
					ram_wdata = rdata;
				end
			end
			S_INS_WR: begin
				ram_we = 1'b1;
			end
			S_PURGE: begin
				// compact survivors toward the bottom
				if (pend_s1 && cmp.spd_ge) begin
					ram_we    = 1'b1;
					ram_waddr = IDX_W'(kept_q);
					ram_wdata = rdata;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			new_q    <= '0;
			cnt_q    <= '0;
			kept_q   <= '0;
			rd_ptr_q <= '0;
			rd_on_q  <= 1'b0;
			pend_s1  <= 1'b0;
			idx_s1   <= '0;
			pos_q    <= '0;
			res_q    <= '0;
		end else begin
			// read issue pipeline, shared by the walking states
			if (state_q == S_INS || state_q == S_LOOK || state_q == S_PURGE) begin
				pend_s1 <= rd_on_q;
				idx_s1  <= rd_ptr_q;
				if (rd_on_q) begin
					if (rd_at_end) begin
						rd_on_q <= 1'b0;
					end else if (state_q == S_INS) begin
						rd_ptr_q <= rd_ptr_q - IDX_W'(1);
					end else begin
						rd_ptr_q <= rd_ptr_q + IDX_W'(1);
					end
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						new_q    <= in_ent;
						pend_s1  <= 1'b0;
						rd_on_q  <= 1'b1;
						kept_q   <= '0;
						// insert walks down from the top entry, the others up from zero
						rd_ptr_q <= (in_op == OP_INSERT) ? last_idx : '0;
						unique case (in_op)
							OP_INSERT: begin
								if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
									res_q   <= '{status: ST_FULL, ent: '0,
										tally: to_tally(cnt_q), last: 1'b1};
									state_q <= S_RESP;
								end else if (cnt_q == '0) begin
									pos_q   <= '0;
									state_q <= S_INS_WR;
								end else begin
									state_q <= S_INS;
								end
							end
							OP_LOOKUP: begin
								if (cnt_q == '0) begin
									res_q   <= '{status: ST_NOTFOUND, ent: '0,
										tally: '0, last: 1'b1};
									state_q <= S_RESP;
								end else begin
									state_q <= S_LOOK;
								end
							end
							OP_PURGE: begin
								if (cnt_q == '0) begin
									res_q   <= '{status: ST_OK, ent: '0,
										tally: '0, last: 1'b1};
									state_q <= S_RESP;
								end else begin
									state_q <= S_PURGE;
								end
							end
							OP_DUMP: begin
								if (cnt_q == '0) begin
									res_q   <= '{status: ST_OK, ent: '0,
										tally: '0, last: 1'b1};
									state_q <= S_RESP;
								end else begin
									state_q <= S_DUMP_RD;
								end
							end
						endcase
					end
				end
				S_INS: begin
					if (pend_s1) begin
						if (!cmp.key_gt) begin
							pos_q   <= idx_s1 + IDX_W'(1);
							state_q <= S_INS_WR;
						end else if (idx_s1 == '0) begin
							pos_q   <= '0;
							state_q <= S_INS_WR;
						end
					end
				end
				S_INS_WR: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					res_q   <= '{status: ST_OK, ent: new_q,
						tally: to_tally(cnt_q + CNT_W'(1)), last: 1'b1};
					state_q <= S_RESP;
				end
				S_LOOK: begin
					if (pend_s1) begin
						if (cmp.key_eq) begin
							res_q   <= '{status: ST_OK, ent: rdata,
								tally: to_tally(cnt_q), last: 1'b1};
							state_q <= S_RESP;
						end else if (idx_s1 == last_idx) begin
							res_q   <= '{status: ST_NOTFOUND, ent: '0,
								tally: to_tally(cnt_q), last: 1'b1};
							state_q <= S_RESP;
						end
					end
				end
				S_PURGE: begin
					if (pend_s1) begin
						kept_q <= kept_nx;
						if (idx_s1 == last_idx) begin
							cnt_q   <= kept_nx;
							res_q   <= '{status: ST_OK, ent: '0,
								tally: to_tally(cnt_q - kept_nx), last: 1'b1};
							state_q <= S_RESP;
						end
					end
				end
				S_DUMP_RD: begin
					state_q <= S_DUMP_OUT;
				end
				S_DUMP_OUT: begin
					if (res_ready) begin
						if (rd_ptr_q == last_idx) begin
							state_q <= S_IDLE;
						end else begin
							rd_ptr_q <= rd_ptr_q + IDX_W'(1);
							state_q  <= S_DUMP_RD;
						end
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> design/sorted_keyed_table_unit.sv
// top level of the sorted keyed table: ports, threshold register, output register
//
// a table of up to 16 entries (key, speed, payload) kept sorted by ascending key
// in a single ram; one compare unit is reused by a small sequencer that walks
// the ram one entry per cycle for insert, lookup and purge
// input channel: in_valid/in_ready with op, key_id, speed_in, payload_in; an
//   item transfers when both are high; in_ready is high only while the
//   sequencer is idle, so one item is worked on at a time
// output channel: out_valid/out_ready with status, out_key, out_speed,
//   out_payload, tally, last; last marks the final result of an item
// pacing: the insert, lookup and purge walks are set by the single ram read port,
//   one entry per cycle with a registered read, and the next item transfers only
//   once the result has left the sequencer; a dump reads each entry and offers it
//   as a result, reading the next entry only after that result is taken
// results land in an output register; while a stalled receiver holds it, the
//   sequencer finishes one more item and waits with its result, input held off
// cfg_we writes cfg_wdata into the purge speed threshold at any clock edge;
//   write it only while the block is idle
// reset clears the entry count and the output valid and loads threshold 5;
//   there is no clearing pass, the ram is never read beyond the count
`default_nettype none
module sorted_keyed_table_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output      logic                            in_ready,
	input  wire logic [1:0]                      op,
	input  wire logic [skt_pkg::KEY_W-1:0]       key_id,
	input  wire logic [skt_pkg::SPEED_W-1:0]     speed_in,
	input  wire logic [skt_pkg::PAYLOAD_W-1:0]   payload_in,
	output      logic                            out_valid,
	input  wire logic                            out_ready,
	output      logic [1:0]                      status,
	output      logic [skt_pkg::KEY_W-1:0]       out_key,
	output      logic [skt_pkg::SPEED_W-1:0]     out_speed,
	output      logic [skt_pkg::PAYLOAD_W-1:0]   out_payload,
	output      logic [skt_pkg::TALLY_W-1:0]     tally,
	output      logic                            last,
	input  wire logic                            cfg_we,
	input  wire logic [skt_pkg::SPEED_W-1:0]     cfg_wdata
);
	import skt_pkg::*;

	logic [SPEED_W-1:0] thr_q;
	logic               out_valid_q;
	res_t               out_q;

	entry_t in_ent;
	res_t   res;
	logic   res_valid;
	logic   res_ready;

	assign in_ent.key     = key_id;
	assign in_ent.speed   = speed_in;
	assign in_ent.payload = payload_in;

	// output register is free when empty or draining this cycle
	assign res_ready = !out_valid_q || out_ready;

	skt_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_op    (op_t'(op)),
		.in_ent   (in_ent),
		.thr      (thr_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// purge threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload, loaded on each result transfer from the sequencer
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign out_key     = out_q.ent.key;
	assign out_speed   = out_q.ent.speed;
	assign out_payload = out_q.ent.payload;
	assign tally       = out_q.tally;
	assign last        = out_q.last;

endmodule
`default_nettype wire

>>> sim/sorted_keyed_table_unit_tb.sv
// self-checking testbench of the sorted keyed table unit
`default_nettype none
module sorted_keyed_table_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import skt_pkg::*;

	// cycles without any transfer before the run is declared hung
	localparam int QUIET_LIMIT = 3000;
	// long receiver hold-off so the block backs up into its input
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_COUNT = 6;
	localparam int PHASE_ITEMS = 74;

	// one table request as offered on the input channel
	typedef struct {
		op_t                  op;
		logic [KEY_W-1:0]     key;
		logic [SPEED_W-1:0]   speed;
		logic [PAYLOAD_W-1:0] payload;
	} table_req_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           op = OP_INSERT;
	logic [KEY_W-1:0]     key_id = '0;
	logic [SPEED_W-1:0]   speed_in = '0;
	logic [PAYLOAD_W-1:0] payload_in = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           status;
	logic [KEY_W-1:0]     out_key;
	logic [SPEED_W-1:0]   out_speed;
	logic [PAYLOAD_W-1:0] out_payload;
	logic [TALLY_W-1:0]   tally;
	logic                 last;
	logic                 cfg_we = 1'b0;
	logic [SPEED_W-1:0]   cfg_wdata = '0;

	sorted_keyed_table_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.key_id      (key_id),
		.speed_in    (speed_in),
		.payload_in  (payload_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.out_key     (out_key),
		.out_speed   (out_speed),
		.out_payload (out_payload),
		.tally       (tally),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the table, its count and the purge threshold
	logic [KEY_W-1:0]     shadow_key[TABLE_DEPTH];
	logic [SPEED_W-1:0]   shadow_speed[TABLE_DEPTH];
	logic [PAYLOAD_W-1:0] shadow_payload[TABLE_DEPTH];
	int                   shadow_count = 0;
	logic [SPEED_W-1:0]   shadow_threshold = THRESHOLD_RESET;

	table_req_t pending_reqs[$];
	res_t       expected_results[$];
	table_req_t next_req;
	logic [KEY_W-1:0] key_pool[8];

	int   fail_count = 0;
	int   quiet_cycles = 0;
	int   send_gap = 0;
	int   recv_stall = 0;
	int   hold_left = 0;
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	logic idle_en = 1'b1;

	// work out the results of one accepted request and update the shadow table
	task automatic predict_table_op(input op_t req_op, input logic [KEY_W-1:0] k,
			input logic [SPEED_W-1:0] s, input logic [PAYLOAD_W-1:0] p);
		int   pos;
		int   kept;
		res_t r;
		r = '0;
		r.status = ST_OK;
		r.last = 1'b1;
		case (req_op)
			OP_INSERT: begin
				if (shadow_count >= TABLE_DEPTH) begin
					// full table: nothing moves, only the count comes back
					r.status = ST_FULL;
					r.tally = TALLY_W'(shadow_count);
				end else begin
					// new entry lands after every key less than or equal to its own
					pos = 0;
					while (pos < shadow_count && shadow_key[pos] <= k)
						pos++;
					for (int i = shadow_count; i > pos; i--) begin
						shadow_key[i] = shadow_key[i-1];
						shadow_speed[i] = shadow_speed[i-1];
						shadow_payload[i] = shadow_payload[i-1];
					end
					shadow_key[pos] = k;
					shadow_speed[pos] = s;
					shadow_payload[pos] = p;
					shadow_count++;
					r.ent = '{key: k, speed: s, payload: p};
					r.tally = TALLY_W'(shadow_count);
				end
				expected_results.push_back(r);
			end
			OP_LOOKUP: begin
				r.status = ST_NOTFOUND;
				r.tally = TALLY_W'(shadow_count);
				for (int i = 0; i < shadow_count; i++) begin
					if (r.status == ST_NOTFOUND && shadow_key[i] == k) begin
						r.status = ST_OK;
						r.ent = '{key: shadow_key[i], speed: shadow_speed[i],
							payload: shadow_payload[i]};
					end
				end
				expected_results.push_back(r);
			end
			OP_PURGE: begin
				// keep entries at or above the threshold, order preserved
				kept = 0;
				for (int i = 0; i < shadow_count; i++) begin
					if (shadow_speed[i] >= shadow_threshold) begin
						shadow_key[kept] = shadow_key[i];
						shadow_speed[kept] = shadow_speed[i];
						shadow_payload[kept] = shadow_payload[i];
						kept++;
					end
				end
				r.tally = TALLY_W'(shadow_count - kept);
				shadow_count = kept;
				expected_results.push_back(r);
			end
			default: begin
				// dump: one result per entry, empty table gives a single zero result
				if (shadow_count == 0)
					expected_results.push_back(r);
				for (int i = 0; i < shadow_count; i++) begin
					r.ent = '{key: shadow_key[i], speed: shadow_speed[i],
						payload: shadow_payload[i]};
					r.tally = TALLY_W'(shadow_count);
					r.last = (i == shadow_count - 1);
					expected_results.push_back(r);
				end
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// sender: pops requests, holds each until its transfer, inserts idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_table_op(op_t'(op), key_id, speed_in, payload_in);
			// the channel is free once nothing is offered or the offer transfers
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0 && idle_en &&
						$urandom_range(0, 3) == 0) begin
					// start an idle burst, this cycle included, with the rest counted down in send_gap
					send_gap <= $urandom_range(0, 12);
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					next_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					op <= next_req.op;
					key_id <= next_req.key;
					speed_in <= next_req.speed;
					payload_in <= next_req.payload;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall bursts plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall <= 0;
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall <= recv_stall - 1;
			out_ready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			recv_stall <= $urandom_range(0, 12);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// result checker: every output transfer against the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none actual status %0h key %0h",
					$time, status, out_key);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("out_key", 32'(want.ent.key), 32'(out_key));
				check_field("out_speed", 32'(want.ent.speed), 32'(out_speed));
				check_field("out_payload", want.ent.payload, out_payload);
				check_field("tally", 32'(want.tally), 32'(tally));
				check_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	// hang detection: count cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("sorted_keyed_table_unit_tb: errors");
				$finish;
			end
		end
	end

	task automatic queue_req(input op_t o, input logic [KEY_W-1:0] k,
			input logic [SPEED_W-1:0] s, input logic [PAYLOAD_W-1:0] p);
		pending_reqs.push_back('{op: o, key: k, speed: s, payload: p});
	endtask

	// random request: keys mostly from a small pool so lookups hit and keys repeat,
	// speeds clustered around the threshold so purge has work on both sides
	function automatic table_req_t random_req();
		table_req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 48)
			r.op = OP_INSERT;
		else if (pick < 74)
			r.op = OP_LOOKUP;
		else if (pick < 84)
			r.op = OP_PURGE;
		else
			r.op = OP_DUMP;
		if ($urandom_range(0, 3) != 0)
			r.key = key_pool[$urandom_range(0, 7)];
		else
			r.key = KEY_W'($urandom);
		case ($urandom_range(0, 5))
			0: r.speed = '0;
			1: r.speed = '1;
			2: r.speed = shadow_threshold - 1'b1;
			3: r.speed = shadow_threshold;
			4: r.speed = shadow_threshold + 1'b1;
			default: r.speed = SPEED_W'($urandom);
		endcase
		r.payload = $urandom;
		return r;
	endfunction

	// block until every request transferred and every result came back;
	// sampled at the falling edge so the rising edge updates have all landed
	task automatic wait_drained(input int settle);
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [SPEED_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_threshold = v;
	endtask

	initial begin
		logic [SPEED_W-1:0] phase_thr[PHASE_COUNT];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, ordering of equal keys, extremes, full table
		queue_req(OP_DUMP, 16'h0000, 16'h0000, 32'h0000_0000);
		queue_req(OP_LOOKUP, 16'h0000, 16'h0000, 32'h0000_0000);
		queue_req(OP_PURGE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		queue_req(OP_INSERT, 16'h8000, 16'h0005, 32'h1111_1111);
		queue_req(OP_INSERT, 16'h8000, 16'h0004, 32'h2222_2222);
		queue_req(OP_INSERT, 16'h0000, 16'h0000, 32'h0000_0000);
		queue_req(OP_INSERT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		queue_req(OP_INSERT, 16'h8000, 16'h0006, 32'h3333_3333);
		// first of the equal keys must come back
		queue_req(OP_LOOKUP, 16'h8000, 16'h0000, 32'h0000_0000);
		queue_req(OP_LOOKUP, 16'h7FFF, 16'h0000, 32'h0000_0000);
		for (int i = 0; i < 11; i++)
			queue_req(OP_INSERT, KEY_W'(16'hF000 - i * 16'h1357), SPEED_W'(i), $urandom);
		// table now full
		queue_req(OP_INSERT, 16'h1234, 16'h0010, 32'hA5A5_A5A5);
		queue_req(OP_DUMP, 16'h0000, 16'h0000, 32'h0000_0000);
		queue_req(OP_PURGE, 16'h0000, 16'h0000, 32'h0000_0000);
		queue_req(OP_DUMP, 16'h0000, 16'h0000, 32'h0000_0000);
		wait_drained(4);

		// threshold extremes first, then random values, then back to reset value
		phase_thr[0] = '1;
		phase_thr[1] = '0;
		for (int p = 2; p < PHASE_COUNT - 1; p++)
			phase_thr[p] = SPEED_W'($urandom);
		phase_thr[PHASE_COUNT-1] = THRESHOLD_RESET;

		for (int p = 0; p < PHASE_COUNT; p++) begin
			set_threshold(phase_thr[p]);
			key_pool[0] = '0;
			key_pool[7] = '1;
			for (int i = 1; i < 7; i++)
				key_pool[i] = KEY_W'($urandom);
			// final phase runs at full rate on both sides
			if (p == PHASE_COUNT - 1)
				idle_en <= 1'b0;
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_reqs.push_back(random_req());
			// back-pressure test: receiver stops while the sender keeps offering
			if (p == 1)
				hold_req <= 1'b1;
			wait_drained(4);
		end

		wait_drained(40);
		if (fail_count == 0)
			$display("sorted_keyed_table_unit_tb: clean");
		else
			$display("sorted_keyed_table_unit_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire
